// ----- sv/swmh_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmh_pkg
// Constants and types shared by the word hash block.
// ----------------------------------------------------------------------------
package swmh_pkg;

  localparam int unsigned MAX_WORDS = 64;
  localparam int unsigned CNT_W     = $clog2(MAX_WORDS + 1);

  localparam logic [31:0] X_INIT = 32'h37A8_470E;
  localparam logic [31:0] Y_INIT = 32'h7758_B42B;
  localparam logic [31:0] V_INIT = 32'hF4FA_8928;
  localparam logic [31:0] W_BASE = 32'h267B_0B11;
  localparam logic [31:0] TRAIL0 = 32'h9BE7_4448;
  localparam logic [31:0] TRAIL1 = 32'h66F4_2C48;
  localparam logic [31:0] A_OR   = 32'h0204_0801;
  localparam logic [31:0] A_AND  = 32'hBFEF_7FDF;
  localparam logic [31:0] B_OR   = 32'h0080_4021;
  localparam logic [31:0] B_AND  = 32'h7DFE_FBFF;

  typedef logic [31:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MULX,
    ST_MULY,
    ST_FOLDY
  } state_e;

  typedef enum logic [1:0] {
    PH_MSG,
    PH_TR0,
    PH_TR1
  } phase_e;

endpackage

// ----- sv/string_word_mult_hash_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_word_mult_hash_top
// Multiplicative hash of a name delivered as 32-bit little-endian words.
// ----------------------------------------------------------------------------
// Every absorbed word runs through one shared 32x32 multiplier in the busy
// steps prepare, x product, y product and y fold, and the next word is taken
// only once the block is idle again. A zero word, or the word that reaches
// the word limit, triggers two trailer rounds. The last trailer round holds
// its result only while a previous hash still waits in the output register;
// the block then returns to its reset state. A finished hash sits in an
// output register, so the next message word can be taken while it waits;
// only a second result stalls on a full register.
module string_word_mult_hash_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  swmh_pkg::word_t      message_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output swmh_pkg::word_t      hash_value_o
);
  import swmh_pkg::*;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  word_t  x_acc_q, y_acc_q, rot_key_q;
  count_t word_count_q, word_count_d;
  word_t  word_q;
  word_t  x_q, y_q, a_q, b_q;
  logic [63:0] prod_q;
  logic   out_valid_q;
  word_t  hash_q;

  // Round front end
  word_t rot_next, w_val, x_val, y_val, wy_sum, wx_sum;
  // Shared multiplier
  word_t mul_lhs, mul_rhs;
  logic [63:0] mul_res;
  // Folds
  logic [32:0] sx, sy;
  word_t nx, ny;

  logic   in_fire, out_fire, out_free;
  logic   load_word, finish;
  word_t  load_val;
  count_t count_inc;

  assign in_ready_o   = (state_q == ST_IDLE);
  assign in_fire      = in_valid_i & in_ready_o;
  assign out_fire     = out_valid_q & out_ready_i;
  assign out_free     = ~out_valid_q | out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  assign rot_next = {rot_key_q[30:0], rot_key_q[31]};
  assign w_val    = W_BASE ^ rot_next;
  assign x_val    = x_acc_q ^ word_q;
  assign y_val    = y_acc_q ^ word_q;
  assign wy_sum   = w_val + y_val;
  assign wx_sum   = w_val + x_val;

  assign mul_lhs = (state_q == ST_MULX) ? x_q : y_q;
  assign mul_rhs = (state_q == ST_MULX) ? a_q : b_q;
  assign mul_res = 64'(mul_lhs) * 64'(mul_rhs);

  // End-around folds of the product halves
  assign sx = {1'b0, prod_q[31:0]} + {1'b0, prod_q[63:32]}
            + {32'd0, (prod_q[63:32] != 32'd0)};
  assign nx = sx[31:0] + {31'd0, sx[32]};
  assign sy = {1'b0, prod_q[31:0]} + {1'b0, prod_q[62:32], 1'b0}
            + {32'd0, prod_q[63]};
  assign ny = sy[31:0] + (sy[32] ? 32'd2 : 32'd0);

  assign count_inc = word_count_q + count_t'(1);

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    word_count_d = word_count_q;
    load_word    = 1'b0;
    load_val     = TRAIL0;
    finish       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          load_word = 1'b1;
          state_d   = ST_PREP;
          if (message_word_i != 32'd0) begin
            load_val = message_word_i;
            phase_d  = PH_MSG;
          end else begin
            load_val = TRAIL0;
            phase_d  = PH_TR0;
          end
        end
      end
      ST_PREP:  state_d = ST_MULX;
      ST_MULX:  state_d = ST_MULY;
      ST_MULY:  state_d = ST_FOLDY;
      ST_FOLDY: begin
        unique case (phase_q)
          PH_MSG: begin
            word_count_d = count_inc;
            if (count_inc == count_t'(MAX_WORDS)) begin
              load_word = 1'b1;
              load_val  = TRAIL0;
              phase_d   = PH_TR0;
              state_d   = ST_PREP;
            end else begin
              state_d = ST_IDLE;
            end
          end
          PH_TR0: begin
            load_word = 1'b1;
            load_val  = TRAIL1;
            phase_d   = PH_TR1;
            state_d   = ST_PREP;
          end
          PH_TR1: begin
            // hold until the output register can take the result
            if (out_free) begin
              finish  = 1'b1;
              state_d = ST_IDLE;
            end
          end
          default: state_d = ST_IDLE;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_MSG;
      x_acc_q      <= X_INIT;
      y_acc_q      <= Y_INIT;
      rot_key_q    <= V_INIT;
      word_count_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      if (state_q == ST_PREP) begin
        rot_key_q <= rot_next;
      end
      if (state_q == ST_MULY) begin
        x_acc_q <= nx;
      end
      if (finish) begin
        x_acc_q      <= X_INIT;
        y_acc_q      <= Y_INIT;
        rot_key_q    <= V_INIT;
        word_count_q <= '0;
        out_valid_q  <= 1'b1;
      end else begin
        word_count_q <= word_count_d;
        if (state_q == ST_FOLDY) begin
          y_acc_q <= ny;
        end
        if (out_fire) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (load_word) begin
      word_q <= load_val;
    end
    if (state_q == ST_PREP) begin
      x_q <= x_val;
      y_q <= y_val;
      a_q <= (wy_sum | A_OR) & A_AND;
      b_q <= (wx_sum | B_OR) & B_AND;
    end
    if (state_q == ST_MULX || state_q == ST_MULY) begin
      prod_q <= mul_res;
    end
    if (finish) begin
      hash_q <= x_acc_q ^ ny;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multiplicative word hash block.
// ----------------------------------------------------------------------------
// A short table of names covers the empty message, all-ones and single-bit
// words, and short multi-word names. A name that runs into the word limit
// follows. Then come random names, mostly short and zero-terminated, some at
// or just under the word limit, and some loose words. A behavioural hash
// model runs on every accepted word, and each hash beat is compared with the
// oldest predicted value. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
module tb;

  import swmh_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1100;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned N_TABLE     = 22;

  // Directed names: each zero word closes one message.
  localparam word_t NAME_TABLE [N_TABLE] = '{
    32'h0000_0000, 32'h0000_0000,
    32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0001, 32'h0000_0000,
    32'h8000_0000, 32'h0000_0000,
    32'h0000_0041, 32'h0000_0000,
    32'h6C6C_6548, 32'h0000_006F, 32'h0000_0000,
    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
    32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000,
    32'h1234_5678, 32'h0000_0000
  };

  logic  clk_i = 1'b0;
  logic  rst_ni;
  logic  in_valid;
  logic  in_ready;
  word_t msg_word;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t hash_value;

  // Hash model state
  word_t       x_acc_m;
  word_t       y_acc_m;
  word_t       key_m;
  int unsigned words_m;

  word_t       pending_hashes[$];
  int unsigned err_cnt   = 0;
  int unsigned cycle_cnt = 0;
  int unsigned words_sent = 0;
  bit          quiet = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  string_word_mult_hash_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .message_word_i (msg_word),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .hash_value_o   (hash_value)
  );

  function automatic void clear_hash_state();
    x_acc_m = X_INIT;
    y_acc_m = Y_INIT;
    key_m   = V_INIT;
    words_m = 0;
  endfunction

  // One mixing round: rotate key, two masked products, end-around folds.
  function automatic void mix_word(word_t m);
    word_t       w, x, y, a, b, lo, hi;
    logic [63:0] p;
    logic [32:0] s;
    key_m = {key_m[30:0], key_m[31]};
    w = W_BASE ^ key_m;
    x = x_acc_m ^ m;
    y = y_acc_m ^ m;
    a = ((w + y) | A_OR) & A_AND;
    b = ((w + x) | B_OR) & B_AND;
    p  = {32'd0, x} * {32'd0, a};
    lo = p[31:0];
    hi = p[63:32];
    s  = {1'b0, lo} + {1'b0, hi} + 33'(hi != 32'd0);
    x_acc_m = s[31:0] + 32'(s[32]);
    p  = {32'd0, y} * {32'd0, b};
    lo = p[31:0];
    hi = p[63:32];
    s  = {1'b0, lo} + {1'b0, hi[30:0], 1'b0} + 33'(hi[31]);
    y_acc_m = s[31:0] + (s[32] ? 32'd2 : 32'd0);
  endfunction

  // Returns 1 when the word closes the message, with the hash in h.
  function automatic bit hash_predict_word(word_t m, output word_t h);
    h = '0;
    if (m != 32'd0) begin
      mix_word(m);
      words_m++;
      if (words_m < MAX_WORDS) return 1'b0;
    end
    mix_word(TRAIL0);
    mix_word(TRAIL1);
    h = x_acc_m ^ y_acc_m;
    clear_hash_state();
    return 1'b1;
  endfunction

  // Predict on every accepted word, check every hash beat.
  always @(posedge clk_i) begin
    word_t h;
    word_t exp_h;
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        if (hash_predict_word(msg_word, h)) pending_hashes.push_back(h);
      end
      if (out_valid && out_ready) begin
        if (pending_hashes.size() == 0) begin
          $display("%0t: unexpected hash %08h, none pending", $time, hash_value);
          err_cnt++;
        end else begin
          exp_h = pending_hashes.pop_front();
          if (hash_value !== exp_h) begin
            $display("%0t: hash mismatch, expected %08h, got %08h",
                     $time, exp_h, hash_value);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Result side: back-pressure at random, with a chance of about 6 in a hundred
  always @(negedge clk_i) begin
    out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 6);
  end

  // Present one beat; valid stays high across back-to-back beats.
  task automatic send_word(word_t w);
    while (!quiet && $urandom_range(0, 99) < 6) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    msg_word = w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  function automatic word_t rand_name_word();
    word_t w;
    word_t mask;
    case ($urandom_range(0, 3))
      0:       mask = 32'h0000_00FF;
      1:       mask = 32'h0000_FFFF;
      2:       mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
    do w = $urandom() & mask; while (w == 32'd0);
    return w;
  endfunction

  task automatic send_name(int unsigned len, bit close);
    for (int unsigned i = 0; i < len; i++) send_word(rand_name_word());
    if (close) send_word(32'd0);
  endtask

  initial begin
    int unsigned kind;
    bit          paused;
    paused   = 1'b0;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    msg_word = '0;
    clear_hash_state();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int i = 0; i < N_TABLE; i++) send_word(NAME_TABLE[i]);
    // Run into the word limit, then an empty name straight after it
    for (int unsigned i = 0; i < MAX_WORDS; i++)
      send_word((i % 2 == 0) ? 32'hFFFF_FFFF : rand_name_word());
    send_word(32'd0);

    words_sent = 0;
    while (words_sent < RAND_ITEMS) begin
      quiet = (words_sent >= 300) && (words_sent < 500);
      if (!paused && words_sent >= 700) begin
        // hold off until every hash has drained
        in_valid = 1'b0;
        while (pending_hashes.size() != 0) @(negedge clk_i);
        paused = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 80)      send_name($urandom_range(1, 12), 1'b1);
      else if (kind < 85) send_name(MAX_WORDS, 1'b0);
      else if (kind < 90) send_name(MAX_WORDS - 1, 1'b1);
      else begin
        // loose words, sometimes with a stray terminator
        for (int unsigned i = $urandom_range(1, 6); i > 0; i--)
          send_word(($urandom_range(0, 3) == 0) ? 32'd0 : word_t'($urandom()));
      end
    end
    quiet    = 1'b0;
    in_valid = 1'b0;

    while (pending_hashes.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
